// ----- src/srac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srac_pkg
// Shared types and constants of the slot ring acquire/commit controller.
// ----------------------------------------------------------------------------
package srac_pkg;

	localparam int unsigned SLOTS   = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned LEN_W   = 17;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned ACT_W   = 3;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [LEN_W-1:0] MAX_SLOT_BYTES  = LEN_W'(65536);
	localparam logic [LEN_W-1:0] SLOT_BYTES_RST  = LEN_W'(65536);
	localparam logic [CNT_W-1:0] SLOTS_CNT       = CNT_W'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_POS        = IDX_W'(SLOTS - 1);

	// word address of the slot_bytes register
	localparam logic REG_SLOT_BYTES = 1'b0;

	typedef enum logic [ACT_W-1:0] {
		ACT_ACQ_WR  = 3'd0,
		ACT_COMMIT  = 3'd1,
		ACT_ACQ_RD  = 3'd2,
		ACT_RELEASE = 3'd3,
		ACT_CANCEL  = 3'd4,
		ACT_RESET   = 3'd5
	} action_t;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		next_pos = (p == LAST_POS) ? '0 : p + IDX_W'(1);
	endfunction

endpackage
`default_nettype wire

// ----- src/srac_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srac_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srac_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/slot_ring_acquire_commit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_ring_acquire_commit
// Acquire/commit/release controller for an 8-slot single-producer ring.
// ----------------------------------------------------------------------------
// One action is taken per clock while the result path is not stalled; its result
// beat is registered in stage 1 (decision and length-RAM read), then in the output
// register, and back-to-back actions sustain one beat per cycle while out_ready
// stays high. Pointers, fill count and hold/cancel flags live in flops and are
// updated at acceptance; the per-slot byte counts live in a small RAM with a
// registered read, written by commit and release and read by acquire read. A
// write is seen by every later read, so no forwarding is needed. Refused actions
// still return one beat with ok low. slot_bytes is written when paddr[2] is 0.
module slot_ring_acquire_commit
	import srac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,

	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [LEN_W-1:0]  bytes_used,

	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic              ok,
	output      logic [IDX_W-1:0]  slot_index,
	output      logic [LEN_W-1:0]  length_out,
	output      logic [CNT_W-1:0]  pending_count,
	output      logic              cancel_flag
);

	// architectural state
	logic [LEN_W-1:0] slot_bytes_q;
	logic [IDX_W-1:0] write_pos_q, read_pos_q;
	logic [CNT_W-1:0] fill_q;
	logic             wr_held_q, rd_held_q, cancel_q;

	// stage 1: decision made, length read in flight
	logic             valid_s1, ok_s1, len_sel_s1, cxl_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] cnt_s1;

	// output register
	logic             out_valid_q, ok_q, cxl_q;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept, s1_move, cfg_wr;
	logic [LEN_W-1:0] limit;
	logic [LEN_W-1:0] ram_rdata;

	// decision
	logic             d_ok, d_len_sel, d_wr_held, d_rd_held, d_cancel;
	logic [IDX_W-1:0] d_idx, d_wpos, d_rpos;
	logic [CNT_W-1:0] d_fill;
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr;
	logic [LEN_W-1:0] ram_wdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_SLOT_BYTES);
	assign prdata  = (paddr[2] == REG_SLOT_BYTES) ? APB_DW'(slot_bytes_q) : '0;

	assign s1_move  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	assign limit = (slot_bytes_q > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : slot_bytes_q;

	always_comb begin
		d_ok      = 1'b0;
		d_len_sel = 1'b0;
		d_idx     = '0;
		d_wpos    = write_pos_q;
		d_rpos    = read_pos_q;
		d_fill    = fill_q;
		d_wr_held = wr_held_q;
		d_rd_held = rd_held_q;
		d_cancel  = cancel_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = write_pos_q;
		ram_wdata = bytes_used;
		unique case (action)
			ACT_ACQ_WR: begin
				if (!wr_held_q && !cancel_q && (fill_q != SLOTS_CNT)) begin
					d_ok      = 1'b1;
					d_wr_held = 1'b1;
					d_idx     = write_pos_q;
				end
			end
			ACT_COMMIT: begin
				if (wr_held_q && !cancel_q && (bytes_used <= limit)) begin
					d_ok      = 1'b1;
					ram_we    = 1'b1;
					d_wpos    = next_pos(write_pos_q);
					d_fill    = (fill_q != SLOTS_CNT) ? fill_q + CNT_W'(1) : fill_q;
					d_wr_held = 1'b0;
				end
			end
			ACT_ACQ_RD: begin
				if (!rd_held_q && !cancel_q && (fill_q != '0)) begin
					d_ok      = 1'b1;
					d_rd_held = 1'b1;
					d_idx     = read_pos_q;
					d_len_sel = 1'b1;
					ram_re    = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if (rd_held_q) begin
					d_ok      = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = read_pos_q;
					ram_wdata = '0;
					d_rpos    = next_pos(read_pos_q);
					d_fill    = (fill_q != '0) ? fill_q - CNT_W'(1) : fill_q;
					d_rd_held = 1'b0;
				end
			end
			ACT_CANCEL: begin
				d_ok     = 1'b1;
				d_cancel = 1'b1;
			end
			ACT_RESET: begin
				if ((fill_q == '0) && !rd_held_q && !wr_held_q) begin
					d_ok     = 1'b1;
					d_wpos   = '0;
					d_rpos   = '0;
					d_cancel = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	srac_ram #(
		.WIDTH (LEN_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (accept && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && ram_re),
		.raddr (read_pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SLOT_BYTES_RST;
			write_pos_q  <= '0;
			read_pos_q   <= '0;
			fill_q       <= '0;
			wr_held_q    <= 1'b0;
			rd_held_q    <= 1'b0;
			cancel_q     <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				slot_bytes_q <= pwdata[LEN_W-1:0];
			end
			if (accept) begin
				write_pos_q <= d_wpos;
				read_pos_q  <= d_rpos;
				fill_q      <= d_fill;
				wr_held_q   <= d_wr_held;
				rd_held_q   <= d_rd_held;
				cancel_q    <= d_cancel;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1      <= d_ok;
			idx_s1     <= d_idx;
			len_sel_s1 <= d_len_sel;
			cnt_s1     <= d_fill;
			cxl_s1     <= d_cancel;
		end
		if (s1_move) begin
			ok_q  <= ok_s1;
			idx_q <= idx_s1;
			len_q <= len_sel_s1 ? ram_rdata : '0;
			cnt_q <= cnt_s1;
			cxl_q <= cxl_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign slot_index    = idx_q;
	assign length_out    = len_q;
	assign pending_count = cnt_q;
	assign cancel_flag   = cxl_q;

endmodule
`default_nettype wire

// ----- dv/slot_ring_acquire_commit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_ring_acquire_commit_test
// Self-checking bench for the slot ring controller. Every accepted action is
// run through a local ring predictor. Result beats are compared field by
// field, in order. Directed checks cover refusals, cancel and reset rules,
// and the slot_bytes limits. Random producer/consumer traffic follows under
// three sender/receiver stall mixes and several slot_bytes settings.
// ----------------------------------------------------------------------------
module slot_ring_acquire_commit_test
	import srac_pkg::*;
;

	localparam logic [ACT_W-1:0]  ACT_BAD_LO      = 3'd6;
	localparam logic [ACT_W-1:0]  ACT_BAD_HI      = 3'd7;
	localparam logic [APB_AW-1:0] SLOT_BYTES_ADDR = '0;
	localparam int                CYCLE_LIMIT     = 400000;
	localparam int                BATCH_BEATS     = 123;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] slot_idx;
		logic [LEN_W-1:0] len_bytes;
		logic [CNT_W-1:0] pending;
		logic             cancelled;
	} ring_beat_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [APB_AW-1:0] paddr         = '0;
	logic [APB_DW-1:0] pwdata        = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [ACT_W-1:0]  action        = '0;
	logic [LEN_W-1:0]  bytes_used    = '0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic              ok;
	logic [IDX_W-1:0]  slot_index;
	logic [LEN_W-1:0]  length_out;
	logic [CNT_W-1:0]  pending_count;
	logic              cancel_flag;

	// predicted ring state
	logic [IDX_W-1:0]  wr_pos         = '0;
	logic [IDX_W-1:0]  rd_pos         = '0;
	logic [CNT_W-1:0]  ring_fill      = '0;
	logic              wr_held        = 1'b0;
	logic              rd_held        = 1'b0;
	logic              ring_cancelled = 1'b0;
	logic [LEN_W-1:0]  stored_len [SLOTS];
	logic [LEN_W-1:0]  byte_limit     = SLOT_BYTES_RST;

	ring_beat_t expected_beats [$];
	ring_beat_t want_beat;

	int tx_idle_pct  = 37;
	int rx_stall_pct = 53;
	int n_items      = 0;
	int n_granted    = 0;
	int n_checked    = 0;
	int n_cfg_writes = 0;
	int n_fail       = 0;
	int cycle_count  = 0;

	slot_ring_acquire_commit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.bytes_used    (bytes_used),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.slot_index    (slot_index),
		.length_out    (length_out),
		.pending_count (pending_count),
		.cancel_flag   (cancel_flag)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
			$display("slot_ring_acquire_commit_test: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic logic [IDX_W-1:0] advance_pos(input logic [IDX_W-1:0] p);
		return IDX_W'((int'(p) + 1) % SLOTS);
	endfunction

	// applies one action to the predicted ring and returns the beat it should produce
	function automatic ring_beat_t apply_action(input logic [ACT_W-1:0] act,
			input logic [LEN_W-1:0] nbytes);
		ring_beat_t       r;
		logic [LEN_W-1:0] cap;
		r = '0;
		cap = (byte_limit > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : byte_limit;
		case (act)
			ACT_ACQ_WR: begin
				if (!wr_held && !ring_cancelled && ring_fill < SLOTS_CNT) begin
					wr_held = 1'b1;
					r.slot_idx = wr_pos;
					r.ok = 1'b1;
				end
			end
			ACT_COMMIT: begin
				if (wr_held && !ring_cancelled && nbytes <= cap) begin
					stored_len[wr_pos] = nbytes;
					wr_pos = advance_pos(wr_pos);
					ring_fill = ring_fill + CNT_W'(1);
					wr_held = 1'b0;
					r.ok = 1'b1;
				end
			end
			ACT_ACQ_RD: begin
				if (!rd_held && !ring_cancelled && ring_fill != 0) begin
					rd_held = 1'b1;
					r.slot_idx = rd_pos;
					r.len_bytes = stored_len[rd_pos];
					r.ok = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if (rd_held) begin
					stored_len[rd_pos] = '0;
					rd_pos = advance_pos(rd_pos);
					ring_fill = ring_fill - CNT_W'(1);
					rd_held = 1'b0;
					r.ok = 1'b1;
				end
			end
			ACT_CANCEL: begin
				ring_cancelled = 1'b1;
				r.ok = 1'b1;
			end
			ACT_RESET: begin
				if (ring_fill == 0 && !rd_held && !wr_held) begin
					rd_pos = '0;
					wr_pos = '0;
					ring_cancelled = 1'b0;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.pending = ring_fill;
		r.cancelled = ring_cancelled;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, ok %0b slot %0d", $time, ok,
					slot_index);
				n_fail++;
			end else begin
				want_beat = expected_beats.pop_front();
				check_field("ok", 32'(want_beat.ok), 32'(ok));
				check_field("slot_index", 32'(want_beat.slot_idx), 32'(slot_index));
				check_field("length_out", 32'(want_beat.len_bytes), 32'(length_out));
				check_field("pending_count", 32'(want_beat.pending), 32'(pending_count));
				check_field("cancel_flag", 32'(want_beat.cancelled), 32'(cancel_flag));
				n_checked++;
			end
		end
	end

	// one input beat; valid stays high on return so back-to-back beats need no gap
	task automatic send_action(input logic [ACT_W-1:0] act,
			input logic [LEN_W-1:0] nbytes = '0);
		ring_beat_t beat;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		bytes_used <= nbytes;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beat = apply_action(act, nbytes);
		expected_beats.push_back(beat);
		n_items++;
		if (beat.ok) n_granted++;
	endtask

	// hold off input until every result is back, then allow for pipeline latency
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_slot_bytes(input logic [LEN_W-1:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SLOT_BYTES_ADDR;
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		byte_limit = value;
		n_cfg_writes++;
		// read back right away
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[LEN_W-1:0] !== byte_limit) begin
			$display("%0t: slot_bytes readback mismatch, expected %0d actual %0d", $time,
				byte_limit, prdata[LEN_W-1:0]);
			n_fail++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// brings the ring back to empty, unheld and not cancelled
	task automatic ring_recover();
		if (ring_cancelled && rd_held) send_action(ACT_RELEASE);
		if (ring_cancelled) send_action(ACT_RESET);
		if (wr_held) send_action(ACT_COMMIT, '0);
		if (rd_held) send_action(ACT_RELEASE);
		while (ring_fill != 0) begin
			send_action(ACT_ACQ_RD);
			send_action(ACT_RELEASE);
		end
		send_action(ACT_RESET);
	endtask

	task automatic test_sequencing_rules();
		send_action(ACT_ACQ_RD);                   // empty ring
		send_action(ACT_RELEASE);                  // nothing held
		send_action(ACT_COMMIT, '0);               // nothing held
		send_action(ACT_BAD_LO, 17'h1FFFF);
		send_action(ACT_BAD_HI, 17'h15555);
		send_action(ACT_ACQ_WR);
		send_action(ACT_ACQ_WR);                   // already held
		send_action(ACT_COMMIT, 17'h1FFFF);        // over the limit
		send_action(ACT_COMMIT, 17'h10001);
		send_action(ACT_COMMIT, 17'h10000);
		send_action(ACT_RESET);                    // slot pending
		send_action(ACT_ACQ_RD);
		send_action(ACT_ACQ_RD);                   // already held
		send_action(ACT_CANCEL);                   // cancel with a read slot held
		send_action(ACT_ACQ_WR);
		send_action(ACT_COMMIT, 17'h00AAA);
		send_action(ACT_RELEASE);                  // release still allowed
		send_action(ACT_RESET);
		send_action(ACT_CANCEL);
		send_action(ACT_RESET);
	endtask

	task automatic test_slot_bytes_extremes();
		logic [LEN_W-1:0] lims [3];
		logic [LEN_W-1:0] cap;
		lims = '{17'h00000, 17'h00001, 17'h1FFFF};
		foreach (lims[i]) begin
			set_slot_bytes(lims[i]);
			cap = (lims[i] > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : lims[i];
			send_action(ACT_ACQ_WR);
			send_action(ACT_COMMIT, cap + LEN_W'(1));
			send_action(ACT_COMMIT, cap);
			send_action(ACT_ACQ_RD);
			send_action(ACT_RELEASE);
		end
		set_slot_bytes(SLOT_BYTES_RST);
	endtask

	// producer/consumer pairs with random content, a little noise and cancel/reset cycles
	task automatic test_random_traffic(input int tx_pct, input int rx_pct,
			input logic [LEN_W-1:0] lim_a, input logic [LEN_W-1:0] lim_b,
			input logic [LEN_W-1:0] lim_c);
		logic [LEN_W-1:0] lims [3];
		logic [LEN_W-1:0] cap;
		logic [LEN_W-1:0] nbytes;
		logic [ACT_W-1:0] act;
		logic             cancel_ok;
		int               start;
		int               pick;
		int               produce_pct;
		lims = '{lim_a, lim_b, lim_c};
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		foreach (lims[b]) begin
			set_slot_bytes(lims[b]);
			cap = (byte_limit > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : byte_limit;
			produce_pct = $urandom_range(30, 65);
			start = n_items;
			while (n_items - start < BATCH_BEATS) begin
				if ($urandom_range(49) == 0) produce_pct = $urandom_range(30, 65);
				cancel_ok = !wr_held && ((ring_fill == 0 && !rd_held) ||
					(ring_fill == 1 && rd_held));
				pick = $urandom_range(99);
				if (ring_cancelled) begin
					send_action(rd_held ? ACT_RELEASE : ACT_RESET);
				end else if (pick < 8) begin
					act = ACT_W'($urandom_range(7));
					if (act == ACT_CANCEL && !cancel_ok) act = ACT_BAD_LO;
					send_action(act, LEN_W'($urandom()));
				end else if (pick < 12 && cancel_ok) begin
					send_action(ACT_CANCEL);
					send_action(ACT_W'($urandom_range(ACT_ACQ_WR, ACT_ACQ_RD)),
						LEN_W'($urandom()));
				end else if ($urandom_range(99) < produce_pct) begin
					pick = $urandom_range(99);
					if (pick < 10) nbytes = '0;
					else if (pick < 20) nbytes = cap;
					else if (pick < 28) nbytes = cap + LEN_W'(1);
					else if (pick < 33) nbytes = LEN_W'($urandom());
					else nbytes = LEN_W'($urandom_range(0, cap));
					send_action(ACT_ACQ_WR);
					send_action(ACT_COMMIT, nbytes);
				end else begin
					send_action(ACT_ACQ_RD, LEN_W'($urandom()));
					send_action(ACT_RELEASE, LEN_W'($urandom()));
				end
				if ($urandom_range(199) == 0) wait_idle();
			end
		end
	endtask

	// a held write slot under cancel can never be committed or reset away
	task automatic test_cancel_with_write_held();
		ring_recover();
		send_action(ACT_ACQ_WR);
		send_action(ACT_COMMIT, 17'h00005);
		send_action(ACT_ACQ_WR);
		send_action(ACT_CANCEL);
		send_action(ACT_COMMIT, '0);
		send_action(ACT_RESET);
		send_action(ACT_ACQ_RD);
		send_action(ACT_RELEASE);
		send_action(ACT_ACQ_WR);
		send_action(ACT_BAD_HI, '0);
	endtask

	initial begin
		foreach (stored_len[i]) stored_len[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_sequencing_rules();
		test_slot_bytes_extremes();
		test_random_traffic(37, 53, SLOT_BYTES_RST, 17'h00001,
			LEN_W'($urandom_range(2, 65536)));
		test_random_traffic(53, 37, 17'h1FFFF, 17'h00000, LEN_W'($urandom()));
		test_random_traffic(0, 0, LEN_W'($urandom_range(1, 300)), SLOT_BYTES_RST,
			LEN_W'($urandom_range(1, 65536)));
		test_cancel_with_write_held();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("ran %0d actions (%0d granted, %0d refused), %0d result beats checked",
			n_items, n_granted, n_items - n_granted, n_checked);
		$display("slot_bytes written %0d times incl. 0, 1 and out of range; 3 stall mixes",
			n_cfg_writes);
		if (n_fail == 0 && expected_beats.size() == 0) begin
			$display("slot_ring_acquire_commit_test: PASS");
		end else begin
			$display("slot_ring_acquire_commit_test: FAIL");
		end
		$finish;
	end

endmodule
